/* hdl/mi3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg: shared constants and types for the 3x3 matrix inverse unit
// Default widths, element count, minor index table and lane control bundle.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_WIDTH_DEF = 16;
  localparam int OUT_WIDTH_DEF  = 32;
  localparam int N_ELEM         = 9;

  // Cofactor k = a[x]*a[y] - a[z]*a[w], element order row major, transposed
  localparam int MINOR_IDX [N_ELEM][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

  // Per-item flags handed from the determinant stage to the lanes
  typedef struct packed {
    logic d_neg;
    logic sing;
  } det_ctrl_t;

endpackage

/* hdl/mi3_cof.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cof: adjugate cofactors
// Two stages: eighteen 2x2 minor products, then the nine differences.
// ----------------------------------------------------------------------------
module mi3_cof #(
  parameter int EW = 16
) (
  input  logic                 clk,
  input  logic [1:0]           en,
  input  logic signed [EW-1:0] a [9],
  output logic signed [2*EW:0] c [9],
  output logic signed [EW-1:0] arow [3]
);
  import mi3_pkg::*;

  logic signed [2*EW-1:0] p [2*N_ELEM];
  logic signed [EW-1:0]   arow_d [3];

  // minor products
  for (genvar k = 0; k < N_ELEM; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en[0]) begin
        p[2*k]   <= a[MINOR_IDX[k][0]] * a[MINOR_IDX[k][1]];
        p[2*k+1] <= a[MINOR_IDX[k][2]] * a[MINOR_IDX[k][3]];
      end
    end
    // cofactor difference
    always_ff @(posedge clk) begin
      if (en[1]) begin
        c[k] <= (2*EW+1)'(p[2*k]) - (2*EW+1)'(p[2*k+1]);
      end
    end
  end

  // first row follows along for the determinant
  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk) begin
      if (en[0]) arow_d[j] <= a[j];
      if (en[1]) arow[j] <= arow_d[j];
    end
  end

endmodule

/* hdl/mi3_det.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det: determinant by first-row expansion
// Two stages: three products, then the sum with sign and magnitude.
// ----------------------------------------------------------------------------
module mi3_det #(
  parameter int EW = 16
) (
  input  logic                   clk,
  input  logic [1:0]             en,
  input  logic signed [2*EW:0]   c [9],
  input  logic signed [EW-1:0]   arow [3],
  output logic signed [2*EW:0]   c_out [9],
  output logic [3*EW-1:0]        dmag,
  output mi3_pkg::det_ctrl_t     ctrl
);
  import mi3_pkg::*;

  localparam int DW = 3*EW + 1;

  logic signed [DW-1:0]  q [3];
  logic signed [2*EW:0]  c_d [9];
  logic signed [DW-1:0]  det;
  logic signed [DW-1:0]  det_abs;

  // expansion products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      q[0] <= arow[0] * c[0];
      q[1] <= arow[1] * c[3];
      q[2] <= arow[2] * c[6];
    end
  end

  // cofactors ride along two stages
  for (genvar k = 0; k < N_ELEM; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[0]) c_d[k] <= c[k];
      if (en[1]) c_out[k] <= c_d[k];
    end
  end

  assign det     = q[0] + q[1] + q[2];
  assign det_abs = det[DW-1] ? -det : det;

  // sign, magnitude and zero test
  always_ff @(posedge clk) begin
    if (en[1]) begin
      dmag       <= det_abs[3*EW-1:0];
      ctrl.d_neg <= det[DW-1];
      ctrl.sing  <= (det == '0);
    end
  end

endmodule

/* hdl/mi3_div_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div_lane: one inverse element
// Rounded quotient cofactor * 2^(F+G) / det by a pipelined restoring
// divider, one quotient bit per stage, then saturation and sign.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
  parameter int EW = 16,
  parameter int OW = 32
) (
  input  logic                   clk,
  input  logic [OW+2:0]          en,
  input  logic signed [2*EW:0]   c,
  input  logic [3*EW-1:0]        dmag,
  input  mi3_pkg::det_ctrl_t     ctrl,
  output logic signed [OW-1:0]   r,
  output logic                   sing
);
  import mi3_pkg::*;

  localparam int CW = 2*EW + 1;
  localparam int S  = EW - 4 + OW/2 + 1;
  localparam int NW = 2*EW + S + 1;
  localparam int RW = 3*EW + 1;
  localparam int XW = NW + RW + OW;

  logic signed [CW-1:0] c_abs;
  logic [NW-1:0]        num;
  logic [RW-1:0]        den;
  logic                 neg0, sing0;
  logic [XW-1:0]        numx;

  // numerator with rounding term, doubled denominator
  assign c_abs = c[CW-1] ? -c : c;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      num   <= (NW'(c_abs[2*EW-1:0]) << S) + NW'(dmag);
      den   <= {dmag, 1'b0};
      neg0  <= c[CW-1] ^ ctrl.d_neg;
      sing0 <= ctrl.sing;
    end
  end

  logic [RW-1:0] rem_s  [OW+1];
  logic [RW-1:0] den_s  [OW+1];
  logic [OW-1:0] low_s  [OW+1];
  logic [OW-1:0] q_s    [OW+1];
  logic          neg_s  [OW+1];
  logic          ovf_s  [OW+1];
  logic          sing_s [OW+1];

  assign numx = XW'(num);

  // overflow test and initial remainder
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ovf_s[0]  <= numx >= (XW'(den) << OW);
      rem_s[0]  <= RW'(numx >> OW);
      low_s[0]  <= num[OW-1:0];
      den_s[0]  <= den;
      q_s[0]    <= '0;
      neg_s[0]  <= neg0;
      sing_s[0] <= sing0;
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < OW; j++) begin : g_step
    logic [RW:0] t;
    logic        take;
    assign t    = {rem_s[j], low_s[j][OW-1]};
    assign take = t >= {1'b0, den_s[j]};
    always_ff @(posedge clk) begin
      if (en[j+2]) begin
        rem_s[j+1]  <= take ? RW'(t - {1'b0, den_s[j]}) : t[RW-1:0];
        q_s[j+1]    <= {q_s[j][OW-2:0], take};
        low_s[j+1]  <= {low_s[j][OW-2:0], 1'b0};
        den_s[j+1]  <= den_s[j];
        neg_s[j+1]  <= neg_s[j];
        ovf_s[j+1]  <= ovf_s[j];
        sing_s[j+1] <= sing_s[j];
      end
    end
  end

  // saturate, apply sign, force zero when singular
  logic [OW-1:0] lim, mag;
  assign lim = neg_s[OW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
  assign mag = (ovf_s[OW] || q_s[OW] > lim) ? lim : q_s[OW];

  always_ff @(posedge clk) begin
    if (en[OW+2]) begin
      r    <= sing_s[OW] ? '0 : (neg_s[OW] ? -mag : mag);
      sing <= sing_s[OW];
    end
  end

endmodule

/* hdl/matrix_inverse_3x3_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit: 3x3 fixed-point matrix inverse by adjugate
// Input item: nine Q4.F elements. Output item: nine Q(OW/2).(OW/2)
// elements, rounded and saturated, and a singular flag.
//
// Channels: s_* takes one matrix per item, m_* gives one result per item.
// Both accept on a rising edge with tvalid and tready high.
// Pipeline: two cofactor stages, two determinant stages, numerator setup,
// overflow test, one stage per quotient bit in each of the nine divider
// lanes, and the output register. Throughput: one item per cycle while
// m_tready is high; every stage is a pipeline register.
// Stall: each stage holds only when it is full and the one after it holds,
// so bubbles fill while m_tready is low; s_tready falls only once the whole
// pipe is full. Reset clears all valid bits; no item is in flight after.
// A zero determinant gives m_tuser = 1 and all elements zero.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_unit #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int OUT_WIDTH  = mi3_pkg::OUT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22 from bit 0 up
  input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up
  output logic [((9*OUT_WIDTH+7)/8)*8-1:0]  m_tdata,
  // singular
  output logic m_tuser
);
  import mi3_pkg::*;

  localparam int EW     = ELEM_WIDTH;
  localparam int OW     = OUT_WIDTH;
  localparam int NS     = OW + 7;
  localparam int OUT_TW = ((9*OW+7)/8)*8;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic          nxt;

  // stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    nxt = m_tready;
    for (int k = NS-1; k >= 0; k--) begin
      en[k] = !v[k] || nxt;
      nxt   = en[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];

  // unpack elements
  logic signed [EW-1:0] a [9];
  for (genvar i = 0; i < N_ELEM; i++) begin : g_in
    assign a[i] = s_tdata[i*EW +: EW];
  end

  logic signed [2*EW:0] c [9];
  logic signed [EW-1:0] arow [3];
  logic signed [2*EW:0] c_det [9];
  logic [3*EW-1:0]      dmag;
  det_ctrl_t            dctrl;

  mi3_cof #(.EW(EW)) u_cof (
    .clk  (clk),
    .en   (en[1:0]),
    .a    (a),
    .c    (c),
    .arow (arow)
  );

  mi3_det #(.EW(EW)) u_det (
    .clk   (clk),
    .en    (en[3:2]),
    .c     (c),
    .arow  (arow),
    .c_out (c_det),
    .dmag  (dmag),
    .ctrl  (dctrl)
  );

  // nine divider lanes
  logic signed [OW-1:0] r [9];
  logic [8:0]           sing_v;
  logic [9*OW-1:0]      r_flat;

  for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
    mi3_div_lane #(.EW(EW), .OW(OW)) u_lane (
      .clk  (clk),
      .en   (en[NS-1:4]),
      .c    (c_det[i]),
      .dmag (dmag),
      .ctrl (dctrl),
      .r    (r[i]),
      .sing (sing_v[i])
    );
    assign r_flat[i*OW +: OW] = r[i];
  end

  // merge lane results
  assign m_tdata = OUT_TW'(r_flat);
  assign m_tuser = |sing_v;

  // checks
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("singular result with nonzero elements");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

endmodule
